// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/scqp_pkg.sv =====
// ----------------------------------------------------------------------------
// scqp_pkg
// Constants and helpers for the sine/cosine quadrant polynomial pipeline.
// ----------------------------------------------------------------------------
package scqp_pkg;
    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;
    localparam logic [59:0] PIO2_Q56 = 60'h1921FB54442D184;
    localparam int NSTEP = 5;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // Horner coefficients, highest order first
    localparam logic signed [31:0] SIN_COEF [NSTEP+1] = '{
        -32'sd27, 32'sd2959, -32'sd213044, 32'sd8947849, -32'sd178956971, 32'sd1073741824};
    localparam logic signed [31:0] COS_COEF [NSTEP+1] = '{
        -32'sd296, 32'sd26631, -32'sd1491308, 32'sd44739243, -32'sd536870912,
        32'sd1073741824};

    // Q2.30 product, rounded half away from zero (operands below 2^31)
    function automatic logic signed [32:0] qmul(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
        logic        neg;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] p;
        logic [33:0] m;
        neg = a[32] ^ b[32];
        ma  = a[32] ? 32'(-a) : a[31:0];
        mb  = b[32] ? 32'(-b) : b[31:0];
        p   = 64'(ma) * 64'(mb) + 64'(1 << 29);
        m   = {1'b0, p[62:30]};
        qmul = neg ? 33'(-$signed(m)) : 33'($signed(m));
    endfunction

    function automatic logic [31:0] sat_q30(input logic signed [33:0] v);
        if (v > 34'sd1073741824)
            sat_q30 = ONE_Q30;
        else if (v < -34'sd1073741824)
            sat_q30 = -ONE_Q30;
        else
            sat_q30 = v[31:0];
    endfunction
endpackage

// ===== rtl/scqp_reduce.sv =====
// ----------------------------------------------------------------------------
// scqp_reduce
// Quadrant reduction: q, remainder r in Q2.30 and quadrant, three stages.
// ----------------------------------------------------------------------------
module scqp_reduce
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic [31:0]        angle,
    output logic               out_vld,
    output logic signed [32:0] r,
    output logic [1:0]         quad
);
    // stage 1: magnitude times 2/pi
    logic        v1_reg;
    logic        neg1_reg;
    logic [32:0] mag1_reg;
    logic [64:0] prod1_reg;
    // stage 2: q times pi/2
    logic        v2_reg;
    logic        neg2_reg;
    logic [32:0] mag2_reg;
    logic [8:0]  q2_reg;
    logic [68:0] sub2_reg;
    // stage 3: remainder
    logic              v3_reg;
    logic signed [32:0] r3_reg;
    logic [1:0]        quad3_reg;

    logic [32:0] mag_next;
    logic [8:0]  q_next;
    logic [68:0] big;
    logic        rneg;
    logic [68:0] rm56;
    logic [43:0] rm30;
    logic signed [32:0] rs;
    logic [1:0]  qd;

    // most negative angle gives 2^31, still within 32 bits
    assign mag_next = angle[31] ? {1'b0, 32'(-angle)} : {1'b0, angle};
    assign q_next   = prod1_reg[64:56] + 9'(prod1_reg[55]);
    assign big      = {4'd0, mag2_reg, 32'd0};
    assign rneg     = big < sub2_reg;
    assign rm56     = rneg ? sub2_reg - big : big - sub2_reg;
    assign rm30     = 44'((rm56 + 69'(1 << 25)) >> 26);
    always_comb
    begin
        rs = rneg ? -$signed({1'b0, rm30[31:0]}) : $signed({1'b0, rm30[31:0]});
        qd = q2_reg[1:0];
        if (neg2_reg)
        begin
            rs = -rs;
            qd = 2'(-qd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg  <= angle[31];
        mag1_reg  <= mag_next;
        prod1_reg <= 65'(mag_next) * 65'(scqp_pkg::TWO_OVER_PI_Q32);
        neg2_reg  <= neg1_reg;
        mag2_reg  <= mag1_reg;
        q2_reg    <= q_next;
        sub2_reg  <= 69'(q_next) * 69'(scqp_pkg::PIO2_Q56);
        r3_reg    <= rs;
        quad3_reg <= qd;
    end

    assign out_vld = v3_reg;
    assign r       = r3_reg;
    assign quad    = quad3_reg;
endmodule

// ===== rtl/scqp_horner.sv =====
// ----------------------------------------------------------------------------
// scqp_horner
// Both Horner chains, at most one multiply per chain per stage; r^2 first, r*s last.
// ----------------------------------------------------------------------------
module scqp_horner
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  logic signed [32:0] r,
    input  logic [1:0]         quad,
    output logic               out_vld,
    output logic signed [32:0] sp,
    output logic signed [32:0] cp,
    output logic [1:0]         quad_out
);
    localparam int NS = scqp_pkg::NSTEP;

    // index 0: after r^2; 1..NS: Horner steps; NS+1: final r*s
    logic               v_reg    [NS+2];
    logic signed [32:0] r_reg    [NS+2];
    logic signed [32:0] x2_reg   [NS+2];
    logic signed [32:0] s_reg    [NS+2];
    logic signed [32:0] c_reg    [NS+2];
    logic [1:0]         quad_reg [NS+2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS + 2; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_vld;
            for (int i = 1; i < NS + 2; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg[0]    <= r;
        x2_reg[0]   <= scqp_pkg::qmul(r, r);
        s_reg[0]    <= 33'(scqp_pkg::SIN_COEF[0]);
        c_reg[0]    <= 33'(scqp_pkg::COS_COEF[0]);
        quad_reg[0] <= quad;
        for (int i = 1; i <= NS; i++)
        begin
            r_reg[i]    <= r_reg[i-1];
            x2_reg[i]   <= x2_reg[i-1];
            quad_reg[i] <= quad_reg[i-1];
            s_reg[i]    <= 33'(scqp_pkg::SIN_COEF[i])
                           + scqp_pkg::qmul(x2_reg[i-1], s_reg[i-1]);
            c_reg[i]    <= 33'(scqp_pkg::COS_COEF[i])
                           + scqp_pkg::qmul(x2_reg[i-1], c_reg[i-1]);
        end
        r_reg[NS+1]    <= r_reg[NS];
        x2_reg[NS+1]   <= x2_reg[NS];
        quad_reg[NS+1] <= quad_reg[NS];
        s_reg[NS+1]    <= scqp_pkg::qmul(r_reg[NS], s_reg[NS]);
        c_reg[NS+1]    <= c_reg[NS];
    end

    assign out_vld  = v_reg[NS+1];
    assign sp       = s_reg[NS+1];
    assign cp       = c_reg[NS+1];
    assign quad_out = quad_reg[NS+1];
endmodule

// ===== rtl/sine_cosine_quadrant_poly_top.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_quadrant_poly_top
// Sine and cosine of a Q8.24 angle, Q2.30 results.
// ----------------------------------------------------------------------------
// One angle is taken every cycle (busy stays low); done pulses with sine and
// cosine after three reduction stages, seven polynomial stages (at most one
// Q2.30 multiply per chain each) and an output register. The receiver
// cannot stall, so no back-pressure exists.
`include "assert_macros.svh"
module sine_cosine_quadrant_poly_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] angle,
    output logic        done,
    output logic [31:0] sine,
    output logic [31:0] cosine
);
    logic               red_vld;
    logic signed [32:0] red_r;
    logic [1:0]         red_quad;
    logic               pol_vld;
    logic signed [32:0] sp;
    logic signed [32:0] cp;
    logic [1:0]         pol_quad;
    logic               done_reg;
    logic [31:0]        sine_reg;
    logic [31:0]        cosine_reg;
    logic signed [33:0] sv;
    logic signed [33:0] cv;

    assign busy = 1'b0;

    scqp_reduce u_reduce
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start & ~busy),
        .angle   (angle),
        .out_vld (red_vld),
        .r       (red_r),
        .quad    (red_quad)
    );

    scqp_horner u_horner
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (red_vld),
        .r        (red_r),
        .quad     (red_quad),
        .out_vld  (pol_vld),
        .sp       (sp),
        .cp       (cp),
        .quad_out (pol_quad)
    );

    always_comb
    begin
        case (pol_quad)
            2'd0:    begin sv = 34'(sp);  cv = 34'(cp);  end
            2'd1:    begin sv = 34'(cp);  cv = -34'(sp); end
            2'd2:    begin sv = -34'(sp); cv = -34'(cp); end
            default: begin sv = -34'(cp); cv = 34'(sp);  end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= pol_vld;
    end

    always_ff @(posedge clk)
    begin
        sine_reg   <= scqp_pkg::sat_q30(sv);
        cosine_reg <= scqp_pkg::sat_q30(cv);
    end

    assign done   = done_reg;
    assign sine   = sine_reg;
    assign cosine = cosine_reg;

    `ASSERT_NEXT(a_done_follows, clk, rst_n, pol_vld, done)
    `ASSERT_IMPLIES(a_sine_range, clk, rst_n, done,
        $signed(sine) <= 32'sd1073741824 && $signed(sine) >= -32'sd1073741824)
    `ASSERT_IMPLIES(a_cos_range, clk, rst_n, done,
        $signed(cosine) <= 32'sd1073741824 && $signed(cosine) >= -32'sd1073741824)
endmodule

// ===== sim/sine_cosine_quadrant_poly_checker.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_quadrant_poly_checker
// Watches the angle and result channels, predicts sine and cosine of each
// accepted angle and compares every result transaction in order.
// ----------------------------------------------------------------------------
module sine_cosine_quadrant_poly_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] angle,
    input  logic        done,
    input  logic [31:0] sine,
    input  logic [31:0] cosine,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] sine;
        logic [31:0] cosine;
    } trig_pair_t;

    trig_pair_t expected_pairs[$];

    localparam longint SIN_K [6] = '{-27, 2959, -213044, 8947849, -178956971, 1073741824};
    localparam longint COS_K [6] = '{-296, 26631, -1491308, 44739243, -536870912,
                                     1073741824};

    // Q2.30 product, magnitude rounded half away from zero
    function automatic longint fix_mul(longint a, longint b);
        logic   neg;
        longint m;
        neg = (a < 0) != (b < 0);
        m = (((a < 0) ? -a : a) * ((b < 0) ? -b : b) + (64'd1 << 29)) >>> 30;
        return neg ? -m : m;
    endfunction

    function automatic logic [31:0] clip_q30(longint v);
        if (v > 1073741824)
            return 32'd1073741824;
        if (v < -1073741824)
            return -32'sd1073741824;
        return v[31:0];
    endfunction

    function automatic trig_pair_t predict_trig(logic [31:0] a);
        logic        neg;
        logic        rneg;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] big;
        logic [63:0] sub;
        logic [63:0] rm56;
        longint      r;
        longint      x2;
        longint      s;
        longint      c;
        longint      sv;
        longint      cv;
        logic [1:0]  quad;
        trig_pair_t  res;
        neg  = a[31];
        mag  = neg ? (64'd1 << 32) - 64'(a) : 64'(a);
        q    = (mag * 64'hA2F9836E + (64'd1 << 55)) >> 56;
        big  = mag << 32;
        sub  = q * 64'h1921FB54442D184;
        rneg = big < sub;
        rm56 = rneg ? sub - big : big - sub;
        r    = longint'((rm56 + (64'd1 << 25)) >> 26);
        if (rneg)
            r = -r;
        quad = q[1:0];
        if (neg)
        begin
            r = -r;
            quad = -quad;
        end
        x2 = fix_mul(r, r);
        s = SIN_K[0];
        c = COS_K[0];
        for (int k = 1; k < 6; k++)
        begin
            s = SIN_K[k] + fix_mul(x2, s);
            c = COS_K[k] + fix_mul(x2, c);
        end
        s = fix_mul(r, s);
        case (quad)
            2'd0:
            begin
                sv = s;  cv = c;
            end
            2'd1:
            begin
                sv = c;  cv = -s;
            end
            2'd2:
            begin
                sv = -s; cv = -c;
            end
            default:
            begin
                sv = -c; cv = s;
            end
        endcase
        res.sine   = clip_q30(sv);
        res.cosine = clip_q30(cv);
        return res;
    endfunction

    assign pending = expected_pairs.size();

    always @(posedge clk)
    begin
        trig_pair_t exp_pair;
        if (!rst_n)
        begin
            fail_count = 0;
            expected_pairs.delete();
        end
        else
        begin
            // result is checked before this edge's angle is queued
            if (done)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $display("%0t: unexpected result sine=%h cosine=%h", $time, sine, cosine);
                    fail_count++;
                end
                else
                begin
                    exp_pair = expected_pairs.pop_front();
                    if (sine !== exp_pair.sine)
                    begin
                        $display("%0t: sine expected %h actual %h", $time, exp_pair.sine, sine);
                        fail_count++;
                    end
                    if (cosine !== exp_pair.cosine)
                    begin
                        $display("%0t: cosine expected %h actual %h", $time,
                                 exp_pair.cosine, cosine);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_pairs.push_back(predict_trig(angle));
        end
    end
endmodule

// ===== sim/sine_cosine_quadrant_poly_top_tb.sv =====
// ----------------------------------------------------------------------------
// sine_cosine_quadrant_poly_top_tb
// Drives angles (directed extremes, then random) with varying idle gaps and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module sine_cosine_quadrant_poly_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] angle;
    logic        done;
    logic [31:0] sine;
    logic [31:0] cosine;
    int          fail_count;
    int          pending;
    int          idle_pct;

    sine_cosine_quadrant_poly_top u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .angle  (angle),
        .done   (done),
        .sine   (sine),
        .cosine (cosine)
    );

    sine_cosine_quadrant_poly_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .angle      (angle),
        .done       (done),
        .sine       (sine),
        .cosine     (cosine),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // one transaction; start stays high across back-to-back angles
    task automatic send_angle(input logic [31:0] a);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        angle <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] random_angle();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
            2:       return 32'($urandom_range(0, 64)) * 32'h0192_1FB5 / 2
                            + 32'($urandom_range(0, 15)) - 8;
            default: return {{9{1'($urandom_range(1))}}, 23'($urandom)};
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed [] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0192_1FB5, 32'hFE6D_E04B,
            32'h0324_3F6A, 32'hFCDB_C096, 32'h04B6_5F1F, 32'hFB49_A0E1, 32'h0648_7ED5,
            32'h00C9_0FDB, 32'hFF36_F025, 32'h0100_0000, 32'hFF00_0000, 32'h5555_5555,
            32'hAAAA_AAAA, 32'h0000_FFFF};
        start    = 1'b0;
        angle    = '0;
        idle_pct = 0;
        rst_n    = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed[i])
            send_angle(directed[i]);
        start <= 1'b0;
        // hold off until the pipeline has drained
        while (pending != 0)
            @(negedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 78 : (phase == 3) ? 19 : 0;
            for (int n = 0; n < 250; n++)
                send_angle(random_angle());
        end
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/scqp_pkg.sv
rtl/scqp_reduce.sv
rtl/scqp_horner.sv
rtl/sine_cosine_quadrant_poly_top.sv
sim/sine_cosine_quadrant_poly_checker.sv
sim/sine_cosine_quadrant_poly_top_tb.sv
